/* hw/rtl/adc_biquad_cascade_dac_macros.svh */
// ----------------------------------------------------------------------------
// adc_biquad_cascade_dac_macros
// Assertion macros for the biquad cascade; they expect i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ADC_BIQUAD_CASCADE_DAC_MACROS_SVH
`define ADC_BIQUAD_CASCADE_DAC_MACROS_SVH

// same-cycle implication
`define ABQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("abq assertion failed");

// next-cycle implication
`define ABQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("abq assertion failed");

`endif

/* hw/rtl/abq_pkg.sv */
// ----------------------------------------------------------------------------
// abq_pkg
// Widths, coefficient table and control types of the biquad cascade.
// ----------------------------------------------------------------------------
package abq_pkg;

    localparam int ADC_W        = 12;
    localparam int WORD_W       = 32;
    localparam int ACC_W        = 64;
    localparam int POST_SHIFT   = 30;
    localparam int OUT_SHIFT    = 20;
    localparam int SECTIONS_DEF = 4;
    localparam int SECTIONS_MAX = 8;
    localparam int SEC_IDX_W    = 3;
    localparam int TAP_W        = 3;
    localparam int HIST_WORDS   = 4;

    localparam logic [TAP_W-1:0] TAP_X    = 3'd0;
    localparam logic [TAP_W-1:0] TAP_LAST = 3'd4;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    // halved Q31 coefficients: b0, b1, b2, a1, a2
    function automatic logic signed [WORD_W-1:0] abq_coef(
        input logic [SEC_IDX_W-1:0] sec,
        input logic [TAP_W-1:0]     tap
    );
        logic signed [WORD_W-1:0] c;
        c = 32'sd0;
        case (sec)
            3'd0: begin
                case (tap)
                    3'd0:    c = 32'sd1050152231;
                    3'd1:    c = -32'sd2100304461;
                    3'd2:    c = 32'sd1050152231;
                    3'd3:    c = 32'sd2099786147;
                    3'd4:    c = -32'sd1027080952;
                    default: c = 32'sd0;
                endcase
            end
            3'd1: begin
                case (tap)
                    3'd0:    c = 32'sd583361503;
                    3'd1:    c = 32'sd1166723007;
                    3'd2:    c = 32'sd583361503;
                    3'd3:    c = -32'sd1572890246;
                    3'd4:    c = -32'sd580092853;
                    default: c = 32'sd0;
                endcase
            end
            3'd2: begin
                case (tap)
                    3'd0:    c = 32'sd1073741824;
                    3'd1:    c = 32'sd2147483647;
                    3'd2:    c = 32'sd1073741824;
                    3'd3:    c = -32'sd1676130396;
                    3'd4:    c = -32'sd688645970;
                    default: c = 32'sd0;
                endcase
            end
            3'd3: begin
                case (tap)
                    3'd0:    c = 32'sd1073741824;
                    3'd1:    c = 32'sd2147483647;
                    3'd2:    c = 32'sd1073741824;
                    3'd3:    c = -32'sd1891126960;
                    3'd4:    c = -32'sd914706735;
                    default: c = 32'sd0;
                endcase
            end
            default: begin
                case (tap)
                    3'd0:    c = 32'sd1073741824;
                    default: c = 32'sd0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/abq_mac.sv */
// ----------------------------------------------------------------------------
// abq_mac
// Shared 32x32 signed multiplier with a registered product and a wrapping
// 64-bit accumulator; gives the post-shifted 32-bit section result.
// ----------------------------------------------------------------------------
module abq_mac (
    input  logic                                 i_clk,
    input  abq_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [abq_pkg::WORD_W-1:0]    i_coef,
    input  logic signed [abq_pkg::WORD_W-1:0]    i_opnd,
    output logic        [abq_pkg::WORD_W-1:0]    o_y
);
    import abq_pkg::*;

    logic signed [ACC_W-1:0] r_prod;
    logic        [ACC_W-1:0] r_acc;
    logic        [ACC_W-1:0] w_sum;

    assign w_sum = r_acc + r_prod;
    assign o_y   = w_sum[POST_SHIFT+WORD_W-1:POST_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_opnd;
        end
        if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_clr ? '0 : w_sum;
        end
    end

endmodule

/* hw/rtl/abq_hist.sv */
// ----------------------------------------------------------------------------
// abq_hist
// Per-section x1, x2, y1, y2 history; one word read a cycle, one section
// shifted on write.
// ----------------------------------------------------------------------------
module abq_hist #(
    parameter int SECTIONS = abq_pkg::SECTIONS_DEF,
    parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [SEC_W-1:0]              i_sec,
    input  logic [1:0]                    i_word,
    output logic [abq_pkg::WORD_W-1:0]    o_rd,
    input  logic                          i_wr,
    input  logic [abq_pkg::WORD_W-1:0]    i_x_new,
    input  logic [abq_pkg::WORD_W-1:0]    i_y_new
);
    import abq_pkg::*;

    logic [WORD_W-1:0] r_hist [SECTIONS][HIST_WORDS];

    assign o_rd = r_hist[i_sec][i_word];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                for (int w = 0; w < HIST_WORDS; w++) begin
                    r_hist[s][w] <= '0;
                end
            end
        end else if (i_wr) begin
            r_hist[i_sec][0] <= i_x_new;
            r_hist[i_sec][1] <= r_hist[i_sec][0];
            r_hist[i_sec][2] <= i_y_new;
            r_hist[i_sec][3] <= r_hist[i_sec][2];
        end
    end

endmodule

/* hw/rtl/adc_biquad_cascade_dac.sv */
// ----------------------------------------------------------------------------
// adc_biquad_cascade_dac
// ADC sample in, cascade of direct-form-I Q31 biquads on one shared
// multiplier, clamped DAC sample out.
//
//   channel  direction  valid         stall         payload
//   adc      in         i_adc_valid   o_adc_stall   i_adc_sample
//   dac      out        o_dac_valid   i_dac_stall   o_dac_sample
//
// Each item runs, per section, one multiply step for each of the five taps
// (b0, b1, b2, a1, a2) and then a sum-and-store step on the single multiplier,
// then an output step and an idle step, in which alone the next item is taken.
// Synchronous reset clears the sequencer, the output valid and all history.
// A stalled dac item stays in the output register while the next item is
// taken and run; the sequencer then holds in its output step until it frees.
// ----------------------------------------------------------------------------
`include "adc_biquad_cascade_dac_macros.svh"

module adc_biquad_cascade_dac #(
    parameter int SECTIONS = abq_pkg::SECTIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adc_valid,
    output logic                          o_adc_stall,
    input  logic [abq_pkg::ADC_W-1:0]     i_adc_sample,
    output logic                          o_dac_valid,
    input  logic                          i_dac_stall,
    output logic [abq_pkg::ADC_W-1:0]     o_dac_sample
);
    import abq_pkg::*;

    localparam int               SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);
    localparam int               DAC_MAX  = (1 << ADC_W) - 1;
    localparam int               MID      = 1 << (ADC_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_LAST,
        ST_OUT
    } t_state;

    t_state            r_state;
    logic [SEC_W-1:0]  r_sec;
    logic [TAP_W-1:0]  r_tap;
    logic [WORD_W-1:0] r_x;
    logic              r_dac_valid;
    logic [ADC_W-1:0]  r_dac;

    t_mac_ctl                  w_mac_ctl;
    logic signed [WORD_W-1:0]  w_coef;
    logic signed [WORD_W-1:0]  w_opnd;
    logic        [WORD_W-1:0]  w_hist_rd;
    logic        [WORD_W-1:0]  w_y;
    logic        [1:0]         w_word;
    logic                      w_hist_wr;
    logic                      w_in_take;
    logic                      w_out_free;
    logic signed [ADC_W:0]     w_dac_sum;
    logic        [ADC_W-1:0]   w_dac_clamp;

    assign o_adc_stall  = (r_state != ST_IDLE);
    assign o_dac_valid  = r_dac_valid;
    assign o_dac_sample = r_dac;

    assign w_in_take  = i_adc_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_dac_valid || !i_dac_stall;
    assign w_hist_wr  = (r_state == ST_LAST);

    assign w_word = 2'(r_tap - 3'd1);
    assign w_coef = abq_coef(SEC_IDX_W'(r_sec), r_tap);
    assign w_opnd = (r_tap == TAP_X) ? r_x : w_hist_rd;

    always_comb begin
        w_mac_ctl.mul_en  = (r_state == ST_MAC);
        w_mac_ctl.acc_en  = (r_state == ST_MAC);
        w_mac_ctl.acc_clr = (r_tap == TAP_X);
    end

    assign w_dac_sum = (ADC_W+1)'(signed'(r_x[WORD_W-1:OUT_SHIFT])) + (ADC_W+1)'(MID);

    always_comb begin
        if (w_dac_sum < 0) begin
            w_dac_clamp = '0;
        end else if (w_dac_sum > (ADC_W+1)'(DAC_MAX)) begin
            w_dac_clamp = ADC_W'(DAC_MAX);
        end else begin
            w_dac_clamp = w_dac_sum[ADC_W-1:0];
        end
    end

    abq_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_coef (w_coef),
        .i_opnd (w_opnd),
        .o_y    (w_y)
    );

    abq_hist #(
        .SECTIONS (SECTIONS),
        .SEC_W    (SEC_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (r_sec),
        .i_word  (w_word),
        .o_rd    (w_hist_rd),
        .i_wr    (w_hist_wr),
        .i_x_new (r_x),
        .i_y_new (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sec       <= '0;
            r_tap       <= TAP_X;
            r_dac_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && w_out_free) begin
                r_dac       <= w_dac_clamp;
                r_dac_valid <= 1'b1;
            end else if (r_dac_valid && !i_dac_stall) begin
                r_dac_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        r_x     <= {~i_adc_sample[ADC_W-1], i_adc_sample[ADC_W-2:0],
                                    (WORD_W-ADC_W)'(0)};
                        r_sec   <= '0;
                        r_tap   <= TAP_X;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == TAP_LAST) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_x   <= w_y;
                    r_tap <= TAP_X;
                    if (r_sec == SEC_LAST) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_sec   <= r_sec + 1'b1;
                        r_state <= ST_MAC;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `ABQ_ASSERT_NXT(a_take_starts, w_in_take, (r_state == ST_MAC) && (r_sec == '0) && (r_tap == TAP_X))
    `ABQ_ASSERT_IMP(a_tap_range, r_state == ST_MAC, r_tap <= TAP_LAST)
    `ABQ_ASSERT_NXT(a_last_to_out, (r_state == ST_LAST) && (r_sec == SEC_LAST), r_state == ST_OUT)
    `ABQ_ASSERT_NXT(a_out_loads, (r_state == ST_OUT) && w_out_free, r_dac_valid && (r_state == ST_IDLE))

endmodule

/* sim/adc_biquad_cascade_dac_chk.sv */
// ----------------------------------------------------------------------------
// adc_biquad_cascade_dac_chk
// Watches the adc and dac channels of the biquad cascade. It predicts each
// dac item from its own direct-form-I Q31 section history and compares the
// results in order. It reports the number of mismatches, the expected items
// still outstanding and the number of items checked.
// ----------------------------------------------------------------------------
module adc_biquad_cascade_dac_chk
    import abq_pkg::*;
#(
    parameter int SECTIONS = SECTIONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adc_valid,
    input  logic             i_adc_stall,
    input  logic [ADC_W-1:0] i_adc_sample,
    input  logic             i_dac_valid,
    input  logic             i_dac_stall,
    input  logic [ADC_W-1:0] i_dac_sample,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [WORD_W-1:0] MIDPOINT = 32'sd2048;
    localparam logic signed [WORD_W-1:0] DAC_MAX  = 32'sd4095;

    logic signed [WORD_W-1:0] sec_x1 [SECTIONS];
    logic signed [WORD_W-1:0] sec_x2 [SECTIONS];
    logic signed [WORD_W-1:0] sec_y1 [SECTIONS];
    logic signed [WORD_W-1:0] sec_y2 [SECTIONS];

    logic [ADC_W-1:0] dac_expected_q [$];
    int               mismatches = 0;
    int               checked    = 0;

    // b0, b1, b2, a1, a2 of one section, halved Q31
    function automatic logic [5*WORD_W-1:0] section_taps(input int sec);
        case (sec)
            0: return {32'sd1050152231, -32'sd2100304461, 32'sd1050152231,
                       32'sd2099786147, -32'sd1027080952};
            1: return {32'sd583361503, 32'sd1166723007, 32'sd583361503,
                       -32'sd1572890246, -32'sd580092853};
            2: return {32'sd1073741824, 32'sd2147483647, 32'sd1073741824,
                       -32'sd1676130396, -32'sd688645970};
            3: return {32'sd1073741824, 32'sd2147483647, 32'sd1073741824,
                       -32'sd1891126960, -32'sd914706735};
            default: return {32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        endcase
    endfunction

    function automatic logic [ADC_W-1:0] filter_sample(input logic [ADC_W-1:0] adc);
        logic [5*WORD_W-1:0]      taps;
        logic signed [WORD_W-1:0] b0, b1, b2, a1, a2;
        logic signed [WORD_W-1:0] x, y, level;
        logic signed [ACC_W-1:0]  acc, shifted;
        int                       s;
        x = ({20'd0, adc} - 32'd2048) << OUT_SHIFT;
        for (s = 0; s < SECTIONS; s++) begin
            taps = section_taps(s);
            b0 = taps[5*WORD_W-1:4*WORD_W];
            b1 = taps[4*WORD_W-1:3*WORD_W];
            b2 = taps[3*WORD_W-1:2*WORD_W];
            a1 = taps[2*WORD_W-1:WORD_W];
            a2 = taps[WORD_W-1:0];
            acc = b0 * x + b1 * sec_x1[s] + b2 * sec_x2[s]
                + a1 * sec_y1[s] + a2 * sec_y2[s];
            shifted = acc >>> POST_SHIFT;
            y = shifted[WORD_W-1:0];
            sec_x2[s] = sec_x1[s];
            sec_x1[s] = x;
            sec_y2[s] = sec_y1[s];
            sec_y1[s] = y;
            x = y;
        end
        level = (x >>> OUT_SHIFT) + MIDPOINT;
        if (level < 0) begin
            level = 0;
        end
        if (level > DAC_MAX) begin
            level = DAC_MAX;
        end
        return level[ADC_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [ADC_W-1:0] want;
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                sec_x1[s] = '0;
                sec_x2[s] = '0;
                sec_y1[s] = '0;
                sec_y2[s] = '0;
            end
            dac_expected_q.delete();
        end else begin
            if (i_dac_valid && !i_dac_stall) begin
                if (dac_expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: dac item with none expected: expected none, actual %0d",
                             $realtime, i_dac_sample);
                end else begin
                    want = dac_expected_q.pop_front();
                    checked++;
                    if (i_dac_sample !== want) begin
                        mismatches++;
                        $display("%0t: dac_sample mismatch: expected %0d, actual %0d",
                                 $realtime, want, i_dac_sample);
                    end
                end
            end
            if (i_adc_valid && !i_adc_stall) begin
                dac_expected_q.push_back(filter_sample(i_adc_sample));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= dac_expected_q.size();
        o_checked    <= checked;
    end

endmodule

/* sim/adc_biquad_cascade_dac_tb.sv */
// ----------------------------------------------------------------------------
// adc_biquad_cascade_dac_tb
// Drives the biquad cascade with directed edge samples and then random
// audio-like sample streams under three flow-control phases; the checker
// beside the block predicts and compares every dac item.
// ----------------------------------------------------------------------------
module adc_biquad_cascade_dac_tb;
    import abq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_GAP      = 30;
    localparam int PHASE_ITEMS  = 460;
    localparam int DIR_COUNT    = 25;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_adc_valid  = 1'b0;
    logic [ADC_W-1:0] i_adc_sample = '0;
    logic             i_dac_stall  = 1'b0;
    logic             o_adc_stall;
    logic             o_dac_valid;
    logic [ADC_W-1:0] o_dac_sample;

    int fail_count;
    int pending;
    int checked;
    int sent          = 0;
    int cycle_count   = 0;
    int send_idle_pct = 12;
    int recv_idle_pct = 80;

    logic [ADC_W-1:0] edge_samples [DIR_COUNT] = '{
        12'd0, 12'd4095, 12'd2048, 12'd2047, 12'd2049, 12'd1, 12'd4094,
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0,
        12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
        12'd2048, 12'd2048, 12'd1365, 12'd2730
    };

    always #HALF_PERIOD i_clk = ~i_clk;

    adc_biquad_cascade_dac u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adc_valid  (i_adc_valid),
        .o_adc_stall  (o_adc_stall),
        .i_adc_sample (i_adc_sample),
        .o_dac_valid  (o_dac_valid),
        .i_dac_stall  (i_dac_stall),
        .o_dac_sample (o_dac_sample)
    );

    adc_biquad_cascade_dac_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adc_valid  (i_adc_valid),
        .i_adc_stall  (o_adc_stall),
        .i_adc_sample (i_adc_sample),
        .i_dac_valid  (o_dac_valid),
        .i_dac_stall  (i_dac_stall),
        .i_dac_sample (o_dac_sample),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        i_dac_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_count, pending);
            $display("adc_biquad_cascade_dac_tb: FAIL");
            $finish;
        end
    end

    task automatic send_sample(input logic [ADC_W-1:0] smp);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_adc_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_adc_valid  <= 1'b1;
        i_adc_sample <= smp;
        @(posedge i_clk);
        while (o_adc_stall) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    // mix of white noise, slow wander, full-scale toggling and held levels
    task automatic send_stream(input int count);
        int n, kind, len, k, level;
        n = 0;
        while (n < count) begin
            kind  = $urandom_range(3);
            len   = $urandom_range(40, 8);
            level = $urandom_range(4095);
            for (k = 0; k < len && n < count; k++) begin
                case (kind)
                    0: send_sample(ADC_W'($urandom_range(4095)));
                    1: begin
                        level = level + $urandom_range(128) - 64;
                        if (level < 0) begin
                            level = 0;
                        end else if (level > 4095) begin
                            level = 4095;
                        end
                        send_sample(ADC_W'(level));
                    end
                    2: send_sample(k[0] ? 12'd4095 : 12'd0);
                    default: send_sample(ADC_W'(level));
                endcase
                n++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIR_COUNT; i++) begin
            send_sample(edge_samples[i]);
        end
        send_stream(PHASE_ITEMS - DIR_COUNT);
        send_idle_pct = 80;
        recv_idle_pct = 12;
        send_stream(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_stream(PHASE_ITEMS);
        i_adc_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d adc items (%0d directed edge samples, rest random streams)",
                 sent, DIR_COUNT);
        $display("checked %0d dac items over three sender/receiver idle phases", checked);
        if (fail_count == 0) begin
            $display("adc_biquad_cascade_dac_tb: PASS");
        end else begin
            $display("adc_biquad_cascade_dac_tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/abq_pkg.sv
hw/rtl/abq_mac.sv
hw/rtl/abq_hist.sv
hw/rtl/adc_biquad_cascade_dac.sv
sim/adc_biquad_cascade_dac_chk.sv
sim/adc_biquad_cascade_dac_tb.sv
